// ----- hdl/mbam_pkg.sv -----
// Shared types and constants for the bit-vector approximate matcher.
package mbam_pkg;

    localparam int PATTERN_BITS_DEF  = 64;
    localparam int ALPHABET_SIZE_DEF = 4;

    localparam int SYM_W      = 2;
    localparam int POS_W      = 32;
    localparam int DIST_W     = 7;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_EQ     = 4;

    localparam int IN_DATA_W  = 40;   // symbol + position, padded to bytes
    localparam int OUT_DATA_W = 40;   // position + distance, padded to bytes

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    localparam logic [DIST_W-1:0] SCORE_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH    = 3'd0,
        CFG_THRESHOLD         = 3'd1,
        CFG_REMOVE_REDUNDANCY = 3'd2,
        CFG_EQ_SYMBOL0        = 3'd3,
        CFG_EQ_SYMBOL1        = 3'd4,
        CFG_EQ_SYMBOL2        = 3'd5,
        CFG_EQ_SYMBOL3        = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_result;

endpackage

// ----- hdl/myers_bitvector_approx_match.sv -----
// Streaming Myers bit-vector approximate matcher with run merging.
//
// Input stream (s_axis): one sequence symbol per transaction, positions in
// descending order. tuser marks a separator (restarts the recurrence), tlast
// marks the final symbol of a stream (flushes any pending match and restarts).
// Output stream (m_axis): match reports, start position and edit distance;
// tlast is set on the last report caused by one input symbol (at most two).
// Configuration channel (i_cfg_*): register writes, taken every cycle; write
// only while the block is idle.
// A symbol is registered at the input and evaluated in the next cycle; its
// reports enter the output queue at the end of that cycle and are presented on
// m_axis from the head of the queue.
// Throughput: one symbol per cycle while s_axis_tready is high; the recurrence
// is one PATTERN_BITS-wide add plus logic in a single stage. Symbols that raise
// two reports are drained through an 8-entry output queue.
// s_axis_tready drops while the queue holds more than four reports, so a
// stalled receiver backs up to the sender and nothing is lost.
// Reset (synchronous, active low) restores the configuration registers to their
// defaults, clears the recurrence, the pending match and the output queue.
module myers_bitvector_approx_match #(
    parameter int PATTERN_BITS  = mbam_pkg::PATTERN_BITS_DEF,
    parameter int ALPHABET_SIZE = mbam_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbam_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input symbols
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mbam_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [1:0] symbol, [33:2] position
    input  logic                            s_axis_tuser,  // is_separator
    input  logic                            s_axis_tlast,  // is_last
    // match reports
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mbam_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] position, [38:32] distance
    output logic                            m_axis_tlast   // last_of_run
);
    import mbam_pkg::*;

    localparam int LIDX_W = $clog2(PATTERN_BITS);

    // configuration
    logic [LIDX_W-1:0]       r_len_idx;      // effective length - 1
    logic [DIST_W-1:0]       r_threshold;
    logic                    r_remove_red;
    logic [PATTERN_BITS-1:0] r_eq [NUM_EQ];

    // input register
    logic                    r_in_valid;
    logic [SYM_W-1:0]        r_in_symbol;
    logic                    r_in_sep;
    logic [POS_W-1:0]        r_in_pos;
    logic                    r_in_last;

    // recurrence and run state
    logic [PATTERN_BITS-1:0] r_pv, n_pv;
    logic [PATTERN_BITS-1:0] r_mv, n_mv;
    logic [DIST_W-1:0]       r_score, n_score;
    logic                    r_pend_valid, n_pend_valid;
    logic [POS_W-1:0]        r_pend_pos, n_pend_pos;
    logic [DIST_W-1:0]       r_pend_dist, n_pend_dist;

    // output queue
    t_result                 r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]      r_wr, r_rd;
    logic [FIFO_CW-1:0]      r_cnt;

    logic                    s_accept, m_accept;
    logic [LEN_W-1:0]        cfg_len;
    logic [LIDX_W-1:0]       cfg_len_idx;
    logic [DIST_W-1:0]       restart_score;

    logic [PATTERN_BITS-1:0] eq, xv, xh, ph, mh, ph_sh;
    logic                    res_a_valid, res_b_valid;
    t_result                 res_a, res_b, push0, push1;
    logic [1:0]              push_cnt;

    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign m_accept      = m_axis_tvalid & m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_cnt <= FIFO_CW'(FIFO_DEPTH - 4));

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {{(OUT_DATA_W - POS_W - DIST_W){1'b0}},
                            r_fifo[r_rd].distance, r_fifo[r_rd].position};
    assign m_axis_tlast  = r_fifo[r_rd].last;

    // length clamp: zero acts as one, anything above the vector width saturates
    assign cfg_len = i_cfg_data[LEN_W-1:0];
    always_comb begin
        if (cfg_len == '0) begin
            cfg_len_idx = '0;
        end else if (cfg_len > LEN_W'(PATTERN_BITS)) begin
            cfg_len_idx = LIDX_W'(PATTERN_BITS - 1);
        end else begin
            cfg_len_idx = LIDX_W'(cfg_len - LEN_W'(1));
        end
    end

    assign restart_score = DIST_W'(r_len_idx) + DIST_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_idx    <= LIDX_W'(PATTERN_BITS - 1);
            r_threshold  <= '0;
            r_remove_red <= 1'b1;
            for (int i = 0; i < NUM_EQ; i++) begin
                r_eq[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH:    r_len_idx    <= cfg_len_idx;
                CFG_THRESHOLD:         r_threshold  <= i_cfg_data[DIST_W-1:0];
                CFG_REMOVE_REDUNDANCY: r_remove_red <= i_cfg_data[0];
                CFG_EQ_SYMBOL0:        r_eq[0]      <= i_cfg_data[PATTERN_BITS-1:0];
                CFG_EQ_SYMBOL1:        r_eq[1]      <= i_cfg_data[PATTERN_BITS-1:0];
                CFG_EQ_SYMBOL2:        r_eq[2]      <= i_cfg_data[PATTERN_BITS-1:0];
                CFG_EQ_SYMBOL3:        r_eq[3]      <= i_cfg_data[PATTERN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_symbol <= s_axis_tdata[SYM_W-1:0];
            r_in_pos    <= s_axis_tdata[SYM_W+POS_W-1:SYM_W];
            r_in_sep    <= s_axis_tuser;
            r_in_last   <= s_axis_tlast;
        end
    end

    // Myers recurrence step
    always_comb begin
        eq    = (32'(r_in_symbol) < ALPHABET_SIZE) ? r_eq[r_in_symbol] : '0;
        xv    = eq | r_mv;
        xh    = (((eq & r_pv) + r_pv) ^ r_pv) | eq;
        ph    = r_mv | ~(xh | r_pv);
        mh    = r_pv & xh;
        ph_sh = ph << 1;
    end

    always_comb begin
        n_pv         = r_pv;
        n_mv         = r_mv;
        n_score      = r_score;
        n_pend_valid = r_pend_valid;
        n_pend_pos   = r_pend_pos;
        n_pend_dist  = r_pend_dist;
        res_a_valid  = 1'b0;
        res_b_valid  = 1'b0;
        res_a        = '{position: r_pend_pos, distance: r_pend_dist, last: 1'b1};
        res_b        = res_a;

        if (r_in_valid) begin
            if (r_in_sep) begin
                n_pv    = '1;
                n_mv    = '0;
                n_score = restart_score;
            end else begin
                if (ph[r_len_idx]) begin
                    if (r_score != SCORE_MAX) n_score = r_score + DIST_W'(1);
                end else if (mh[r_len_idx]) begin
                    if (r_score != '0) n_score = r_score - DIST_W'(1);
                end
                n_pv = (mh << 1) | ~(xv | ph_sh);
                n_mv = ph_sh & xv;

                if (n_score <= r_threshold) begin
                    if (r_remove_red) begin
                        if (r_pend_valid) begin
                            if (r_in_pos + POS_W'(1) == r_pend_pos) begin
                                // same run: start moves only on strict improvement
                                if (n_score < r_pend_dist) begin
                                    n_pend_pos  = r_in_pos;
                                    n_pend_dist = n_score;
                                end
                            end else begin
                                res_a_valid = 1'b1;
                                n_pend_pos  = r_in_pos;
                                n_pend_dist = n_score;
                            end
                        end else begin
                            n_pend_valid = 1'b1;
                            n_pend_pos   = r_in_pos;
                            n_pend_dist  = n_score;
                        end
                    end else begin
                        res_a_valid    = 1'b1;
                        res_a.position = r_in_pos;
                        res_a.distance = n_score;
                    end
                end
            end

            if (r_in_last) begin
                res_b_valid    = n_pend_valid;
                res_b.position = n_pend_pos;
                res_b.distance = n_pend_dist;
                n_pend_valid   = 1'b0;
                n_pv           = '1;
                n_mv           = '0;
                n_score        = restart_score;
            end
        end

        res_a.last = !res_b_valid;
        push0      = res_a_valid ? res_a : res_b;
        push1      = res_b;
        push_cnt   = {1'b0, res_a_valid} + {1'b0, res_b_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv         <= '1;
            r_mv         <= '0;
            r_score      <= DIST_W'(PATTERN_BITS);
            r_pend_valid <= 1'b0;
            r_pend_pos   <= '0;
            r_pend_dist  <= '0;
        end else begin
            r_pv         <= n_pv;
            r_mv         <= n_mv;
            r_score      <= n_score;
            r_pend_valid <= n_pend_valid;
            r_pend_pos   <= n_pend_pos;
            r_pend_dist  <= n_pend_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr] <= push0;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wr + FIFO_AW'(1)] <= push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(push_cnt);
            r_rd  <= r_rd + FIFO_AW'(m_accept);
            r_cnt <= r_cnt + FIFO_CW'(push_cnt) - FIFO_CW'(m_accept);
        end
    end

endmodule
